>>> rtl/core/drcr_pkg.sv
package drcr_pkg;

  typedef enum logic [1:0] {
    OP_ADD_MERGE = 2'd0,
    OP_ADD_PLAIN = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_DUMP      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OUT_NONE     = 2'd0,
    OUT_STORED   = 2'd1,
    OUT_BOUNDED  = 2'd2,
    OUT_DROPPED  = 2'd3
  } outcome_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AB_RD,   // absorb: read entry i
    ST_AB_CHK,  // absorb: test and unite
    ST_SH_RD,   // shift down: read entry k
    ST_SH_WR,   // shift down: write entry k-1
    ST_CP_RDI,  // compact: read entry i
    ST_CP_RDJ,  // compact: read entry j
    ST_CP_CHK,
    ST_BB_RD,   // bounding box sweep
    ST_BB_ACC,
    ST_APPEND,
    ST_DUMP_RD,
    ST_DUMP_OUT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic [31:0]        w;
    logic [31:0]        h;
  } box_t;

  function automatic logic touches(box_t a, box_t b);
    logic signed [33:0] ax1, ay1, bx1, by1, ax, ay, bx, by;
    logic xo, yo;
    ax = 34'(a.x);
    ay = 34'(a.y);
    bx = 34'(b.x);
    by = 34'(b.y);
    ax1 = ax + $signed({2'b00, a.w});
    ay1 = ay + $signed({2'b00, a.h});
    bx1 = bx + $signed({2'b00, b.w});
    by1 = by + $signed({2'b00, b.h});
    xo = (ax < bx1) && (bx < ax1);
    yo = (ay < by1) && (by < ay1);
    return (xo && yo) || (((ax1 == bx) || (bx1 == ax)) && yo)
        || (((ay1 == by) || (by1 == ay)) && xo);
  endfunction

  function automatic box_t unite(box_t a, box_t b);
    logic signed [33:0] ar, br, ab, bb, nr, nb, nx, ny;
    logic signed [33:0] dw, dh;
    box_t o;
    ar = 34'(a.x) + $signed({2'b00, a.w});
    br = 34'(b.x) + $signed({2'b00, b.w});
    ab = 34'(a.y) + $signed({2'b00, a.h});
    bb = 34'(b.y) + $signed({2'b00, b.h});
    nr = (ar > br) ? ar : br;
    nb = (ab > bb) ? ab : bb;
    nx = (a.x < b.x) ? 34'(a.x) : 34'(b.x);
    ny = (a.y < b.y) ? 34'(a.y) : 34'(b.y);
    dw = nr - nx;
    dh = nb - ny;
    o.x = nx[32:0];
    o.y = ny[32:0];
    o.w = dw[31:0];
    o.h = dh[31:0];
    return o;
  endfunction

endpackage

>>> rtl/core/dirty_rect_coalescing_region.sv
// Dirty rectangle table held in one synchronous RAM (one read, one write port).
// A dump reads and sends the entries one after another; a coalescing add tests each stored
// entry in turn, shifts the later entries down and restarts on each merge, and compacts the
// stored entries pairwise when the table stays full, before collapsing to a bounding box.
// Throughput: one request at a time; the next is taken once the last result has gone.
// Reset clears the count and sets the capacity register to 16; RAM contents are undefined.
module dirty_rect_coalescing_region #(
  parameter int CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic signed [31:0] rect_x_i,
  input  logic signed [31:0] rect_y_i,
  input  logic [31:0] rect_width_i,
  input  logic [31:0] rect_height_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  entry_total_o,
  output logic [1:0]  outcome_o,
  output logic        is_entry_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic [31:0] out_width_o,
  output logic [31:0] out_height_o,
  output logic        last_o
);
  import drcr_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MAXR = 16;

  box_t mem_q [CAPACITY];
  box_t rd_q;
  logic [AW-1:0] ra, wa;
  logic we;
  box_t wd;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  state_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [4:0] capr_q;
  box_t cand_q, cand_d, ei_q, ei_d;
  logic phase_q, phase_d;      // 0 first absorb, 1 after compaction
  logic ret_q, ret_d;          // shift return: 0 absorb, 1 compact
  logic prog_q, prog_d;
  logic [1:0] oc_q, oc_d;
  logic ov_q, ov_d, oe_q, oe_d, ol_q, ol_d;
  box_t ob_q, ob_d;
  logic [4:0] ot_q, ot_d;

  logic [CW-1:0] cap;
  always_comb begin
    if (32'(capr_q) > CAPACITY) cap = CW'(CAPACITY);
    else cap = CW'(capr_q);
  end

  logic [CW-1:0] dump_n;
  always_comb begin
    if (32'(cnt_q) > MAXR) dump_n = CW'(MAXR);
    else dump_n = cnt_q;
  end

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) capr_q <= 5'd16;
    else if (cfg_valid_i) capr_q <= cfg_data_i;
  end

  assign in_ready_o = (st_q == ST_IDLE) && !ov_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; k_d = k_q;
    cand_d = cand_q; ei_d = ei_q; phase_d = phase_q;
    ret_d = ret_q; prog_d = prog_q; oc_d = oc_q;
    ov_d = ov_q; oe_d = oe_q; ol_d = ol_q; ob_d = ob_q; ot_d = ot_q;
    ra = '0; wa = '0; we = 1'b0; wd = cand_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cand_d.x = 33'(rect_x_i);
          cand_d.y = 33'(rect_y_i);
          cand_d.w = rect_width_i;
          cand_d.h = rect_height_i;
          oc_d = OUT_NONE;
          i_d = '0;
          phase_d = 1'b0;
          case (op_e'(operation_i))
            OP_CLEAR: begin
              cnt_d = '0;
              st_d = ST_RESULT;
            end
            OP_DUMP: begin
              if (cnt_q == '0) st_d = ST_RESULT;
              else st_d = ST_DUMP_RD;
            end
            default: begin
              if (cap == '0 || rect_width_i == '0 || rect_height_i == '0)
                st_d = ST_RESULT;
              else if (op_e'(operation_i) == OP_ADD_PLAIN) begin
                if (cnt_q < cap) st_d = ST_APPEND;
                else begin
                  oc_d = OUT_DROPPED;
                  st_d = ST_RESULT;
                end
              end else st_d = ST_AB_RD;
            end
          endcase
        end
      end
      ST_AB_RD: begin
        ra = i_q[AW-1:0];
        if (i_q >= cnt_q) begin
          if (cnt_q < cap) st_d = ST_APPEND;
          else if (!phase_q) begin
            i_d = '0; prog_d = 1'b0;
            st_d = ST_CP_RDI;
          end else begin
            i_d = '0; st_d = ST_BB_RD;
          end
        end else st_d = ST_AB_CHK;
      end
      ST_AB_CHK: begin
        if (touches(cand_q, rd_q)) begin
          cand_d = unite(cand_q, rd_q);
          k_d = i_q + 1'b1; ret_d = 1'b0;
          st_d = ST_SH_RD;
        end else begin
          i_d = i_q + 1'b1;
          st_d = ST_AB_RD;
        end
      end
      ST_SH_RD: begin
        ra = k_q[AW-1:0];
        if (k_q >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          if (!ret_q) begin
            i_d = '0; st_d = ST_AB_RD;
          end else begin
            j_d = i_q + 1'b1; st_d = ST_CP_RDJ;
          end
        end else st_d = ST_SH_WR;
      end
      ST_SH_WR: begin
        we = 1'b1; wa = AW'(k_q - 1'b1); wd = rd_q;
        k_d = k_q + 1'b1;
        st_d = ST_SH_RD;
      end
      ST_CP_RDI: begin
        ra = i_q[AW-1:0];
        if (cnt_q < 2 || i_q >= cnt_q) begin
          if (prog_q) begin
            prog_d = 1'b0; i_d = '0;
          end else begin
            i_d = '0; phase_d = 1'b1; st_d = ST_AB_RD;
          end
        end else begin
          j_d = i_q + 1'b1;
          st_d = ST_CP_RDJ;
        end
      end
      ST_CP_RDJ: begin
        ra = j_q[AW-1:0];
        if (j_q >= cnt_q) begin
          i_d = i_q + 1'b1; st_d = ST_CP_RDI;
        end else st_d = ST_CP_CHK;
        // entry i arrives on the cycle after ST_CP_RDI
        if (j_q == i_q + 1'b1 && !ret_q) ei_d = rd_q;
        ret_d = 1'b0;
      end
      ST_CP_CHK: begin
        if (touches(ei_q, rd_q)) begin
          ei_d = unite(ei_q, rd_q);
          we = 1'b1; wa = i_q[AW-1:0]; wd = ei_d;
          prog_d = 1'b1;
          k_d = j_q + 1'b1; ret_d = 1'b1;
          st_d = ST_SH_RD;
        end else begin
          j_d = j_q + 1'b1;
          st_d = ST_CP_RDJ;
        end
      end
      ST_BB_RD: begin
        ra = i_q[AW-1:0];
        if (i_q >= cnt_q) begin
          we = 1'b1; wa = '0; wd = cand_q;
          cnt_d = CW'(1);
          oc_d = OUT_BOUNDED;
          st_d = ST_RESULT;
        end else st_d = ST_BB_ACC;
      end
      ST_BB_ACC: begin
        cand_d = unite(cand_q, rd_q);
        i_d = i_q + 1'b1;
        st_d = ST_BB_RD;
      end
      ST_APPEND: begin
        we = 1'b1; wa = cnt_q[AW-1:0]; wd = cand_q;
        cnt_d = cnt_q + 1'b1;
        oc_d = OUT_STORED;
        st_d = ST_RESULT;
      end
      ST_DUMP_RD: begin
        ra = i_q[AW-1:0];
        if (!ov_q || out_ready_i) st_d = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        ov_d = 1'b1; oe_d = 1'b1; ob_d = rd_q; oc_d = OUT_NONE;
        ot_d = 5'(cnt_q);
        ol_d = (i_q + 1'b1 == dump_n);
        i_d = i_q + 1'b1;
        st_d = (i_q + 1'b1 == dump_n) ? ST_IDLE : ST_DUMP_RD;
      end
      ST_RESULT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; oe_d = 1'b0; ob_d = '0; ol_d = 1'b1;
          ot_d = 5'(cnt_d);
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // entry i for compaction: latch when its read returns
  logic cpi_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cpi_q <= 1'b0;
    else cpi_q <= (st_q == ST_CP_RDI) && (st_d == ST_CP_RDJ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cnt_q <= '0; ov_q <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0;
      phase_q <= 1'b0; ret_q <= 1'b0; prog_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ov_q <= ov_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d;
      phase_q <= phase_d; ret_q <= ret_d; prog_q <= prog_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    ei_q <= cpi_q ? rd_q : ei_d;
    oc_q <= oc_d; oe_q <= oe_d; ol_q <= ol_d; ob_q <= ob_d; ot_q <= ot_d;
  end

  assign out_valid_o   = ov_q;
  assign entry_total_o = ot_q;
  assign outcome_o     = oc_q;
  assign is_entry_o    = oe_q;
  assign out_x_o       = ob_q.x[31:0];
  assign out_y_o       = ob_q.y[31:0];
  assign out_width_o   = ob_q.w;
  assign out_height_o  = ob_q.h;
  assign last_o        = ol_q;

endmodule

>>> dv/dirty_rect_coalescing_region_test.sv
`timescale 1ns / 1ps

module dirty_rect_coalescing_region_test;
  import drcr_pkg::*;

  localparam int SLOTS = 16;
  localparam int STALL_LIMIT = 50000;

  typedef struct {
    longint      x;
    longint      y;
    bit [31:0]   w;
    bit [31:0]   h;
  } damage_t;

  typedef struct {
    bit [4:0]    total;
    bit [1:0]    outcome;
    bit          is_entry;
    bit [31:0]   x;
    bit [31:0]   y;
    bit [31:0]   w;
    bit [31:0]   h;
    bit          last;
  } region_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic signed [31:0] rect_x_i = '0;
  logic signed [31:0] rect_y_i = '0;
  logic [31:0] rect_width_i = '0;
  logic [31:0] rect_height_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [4:0]  entry_total_o;
  logic [1:0]  outcome_o;
  logic        is_entry_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic [31:0] out_width_o;
  logic [31:0] out_height_o;
  logic        last_o;

  dirty_rect_coalescing_region uut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  damage_t        rect_tbl [SLOTS];
  int unsigned    rect_count;
  int unsigned    cap_reg;
  region_result_t pending_results [$];

  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned mismatches, requests_sent, results_seen;
  int unsigned stall_token, stall_seen, stall_left;
  int unsigned quiet_cycles;

  // ---------------- predictor ----------------
  function automatic bit rect_touch(damage_t a, damage_t b);
    longint ax1, ay1, bx1, by1;
    bit xo, yo;
    ax1 = a.x + longint'({32'd0, a.w});
    ay1 = a.y + longint'({32'd0, a.h});
    bx1 = b.x + longint'({32'd0, b.w});
    by1 = b.y + longint'({32'd0, b.h});
    xo = (a.x < bx1) && (b.x < ax1);
    yo = (a.y < by1) && (b.y < ay1);
    return (xo && yo) || (((ax1 == b.x) || (bx1 == a.x)) && yo)
        || (((ay1 == b.y) || (by1 == a.y)) && xo);
  endfunction

  function automatic damage_t rect_union(damage_t a, damage_t b);
    longint ar, br, ab, bb, nr, nb;
    damage_t o;
    ar = a.x + longint'({32'd0, a.w});
    br = b.x + longint'({32'd0, b.w});
    ab = a.y + longint'({32'd0, a.h});
    bb = b.y + longint'({32'd0, b.h});
    nr = ar > br ? ar : br;
    nb = ab > bb ? ab : bb;
    o.x = a.x < b.x ? a.x : b.x;
    o.y = a.y < b.y ? a.y : b.y;
    o.w = 32'(nr - o.x);
    o.h = 32'(nb - o.y);
    return o;
  endfunction

  function automatic void drop_slot(int unsigned idx);
    for (int unsigned k = idx + 1; k < rect_count; k++) rect_tbl[k-1] = rect_tbl[k];
    rect_count--;
  endfunction

  function automatic damage_t swallow_touching(damage_t c);
    int unsigned i;
    i = 0;
    while (i < rect_count) begin
      if (rect_touch(c, rect_tbl[i])) begin
        c = rect_union(c, rect_tbl[i]);
        drop_slot(i);
        i = 0;
      end else begin
        i++;
      end
    end
    return c;
  endfunction

  function automatic void pairwise_compact();
    bit progress;
    int unsigned j;
    if (rect_count < 2) return;
    progress = 1'b1;
    while (progress) begin
      progress = 1'b0;
      for (int unsigned i = 0; i < rect_count; i++) begin
        j = i + 1;
        while (j < rect_count) begin
          if (rect_touch(rect_tbl[i], rect_tbl[j])) begin
            rect_tbl[i] = rect_union(rect_tbl[i], rect_tbl[j]);
            drop_slot(j);
            progress = 1'b1;
            j = i + 1;
          end else begin
            j++;
          end
        end
      end
    end
  endfunction

  function automatic outcome_e coalesce_add(damage_t c, int unsigned cap);
    damage_t bounds;
    c = swallow_touching(c);
    if (rect_count < cap) begin
      rect_tbl[rect_count++] = c;
      return OUT_STORED;
    end
    pairwise_compact();
    c = swallow_touching(c);
    if (rect_count < cap) begin
      rect_tbl[rect_count++] = c;
      return OUT_STORED;
    end
    bounds = c;
    for (int unsigned i = 0; i < rect_count; i++) bounds = rect_union(bounds, rect_tbl[i]);
    rect_tbl[0] = bounds;
    rect_count = 1;
    return OUT_BOUNDED;
  endfunction

  function automatic void predict_region(op_e op, logic signed [31:0] x,
                                         logic signed [31:0] y, logic [31:0] w,
                                         logic [31:0] h);
    region_result_t res;
    damage_t r;
    outcome_e oc;
    int unsigned cap;
    cap = cap_reg > SLOTS ? SLOTS : cap_reg;
    r.x = longint'(x);
    r.y = longint'(y);
    r.w = w;
    r.h = h;
    res = '{default: '0};
    oc = OUT_NONE;
    if (op == OP_DUMP) begin
      if (rect_count == 0) begin
        res.last = 1'b1;
        pending_results.push_back(res);
      end
      for (int unsigned k = 0; k < rect_count; k++) begin
        res.total = 5'(rect_count);
        res.is_entry = 1'b1;
        res.x = 32'(rect_tbl[k].x);
        res.y = 32'(rect_tbl[k].y);
        res.w = rect_tbl[k].w;
        res.h = rect_tbl[k].h;
        res.last = (k + 1 == rect_count);
        pending_results.push_back(res);
      end
      return;
    end
    if (op == OP_CLEAR) begin
      rect_count = 0;
    end else if (cap != 0 && w != 0 && h != 0) begin
      if (op == OP_ADD_MERGE) oc = coalesce_add(r, cap);
      else if (rect_count < cap) begin
        rect_tbl[rect_count++] = r;
        oc = OUT_STORED;
      end else oc = OUT_DROPPED;
    end
    res.total = 5'(rect_count);
    res.outcome = oc;
    res.last = 1'b1;
    pending_results.push_back(res);
  endfunction

  // ---------------- driving ----------------
  task automatic send_request(op_e op, logic signed [31:0] x, logic signed [31:0] y,
                              logic [31:0] w, logic [31:0] h);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    rect_x_i      <= x;
    rect_y_i      <= y;
    rect_width_i  <= w;
    rect_height_i <= h;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_region(op, x, y, w, h);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cap_reg = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random();
    int unsigned pick, sel;
    op_e op;
    logic signed [31:0] x, y;
    logic [31:0] w, h;
    pick = $urandom_range(99);
    op = pick < 45 ? OP_ADD_MERGE : pick < 70 ? OP_ADD_PLAIN :
         pick < 92 ? OP_DUMP : OP_CLEAR;
    sel = $urandom_range(9);
    if (sel < 8) begin
      // small grid so that rectangles meet often
      x = $urandom_range(0, 120) - 40;
      y = $urandom_range(0, 120) - 40;
      w = $urandom_range(1, 30);
      h = $urandom_range(1, 30);
      if (sel == 0) w = 0;
    end else begin
      x = $urandom;
      y = $urandom;
      w = $urandom;
      h = $urandom;
    end
    send_request(op, x, y, w, h);
  endtask

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch %s got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    region_result_t e;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        e = pending_results.pop_front();
        if (entry_total_o !== e.total)
          report_mismatch("entry_total", 32'(entry_total_o), 32'(e.total));
        if (outcome_o !== e.outcome)
          report_mismatch("outcome", 32'(outcome_o), 32'(e.outcome));
        if (is_entry_o !== e.is_entry)
          report_mismatch("is_entry", 32'(is_entry_o), 32'(e.is_entry));
        if (out_x_o !== e.x) report_mismatch("out_x", out_x_o, e.x);
        if (out_y_o !== e.y) report_mismatch("out_y", out_y_o, e.y);
        if (out_width_o !== e.w) report_mismatch("out_width", out_width_o, e.w);
        if (out_height_o !== e.h) report_mismatch("out_height", out_height_o, e.h);
        if (last_o !== e.last) report_mismatch("last", 32'(last_o), 32'(e.last));
      end
    end
  end

  // receiver with random back-pressure and an on-request long hold-off
  always @(posedge clk_i) begin
    if (stall_token != stall_seen) begin
      stall_seen = stall_token;
      stall_left = 400;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: watchdog expired with %0d results pending", pending_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_state();
    send_request(OP_DUMP, 0, 0, 0, 0);
    send_request(OP_ADD_MERGE, 5, 5, 0, 7);
    send_request(OP_ADD_PLAIN, 5, 5, 7, 0);
  endtask

  task automatic test_edges_and_extremes();
    send_request(OP_ADD_MERGE, 0, 0, 10, 10);
    send_request(OP_ADD_MERGE, 10, 10, 5, 5);     // corner only: kept apart
    send_request(OP_ADD_MERGE, 10, 0, 4, 3);      // shared edge: merges
    send_request(OP_ADD_MERGE, 2, 2, 3, 3);       // overlap
    send_request(OP_DUMP, 0, 0, 0, 0);
    send_request(OP_CLEAR, 0, 0, 0, 0);
    // bounding width of exactly 2^32 wraps to zero
    send_request(OP_ADD_MERGE, 32'sh8000_0000, 32'sh8000_0000, 32'h8000_0000, 1);
    send_request(OP_ADD_MERGE, 0, 32'sh8000_0000, 32'h8000_0000, 1);
    send_request(OP_ADD_PLAIN, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'hffff_ffff,
                 32'hffff_ffff);
    send_request(OP_DUMP, 0, 0, 0, 0);
    send_request(OP_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_full_table();
    write_capacity(5'd3);
    for (int i = 0; i < 3; i++) send_request(OP_ADD_PLAIN, i * 20, 0, 5, 5);
    send_request(OP_ADD_PLAIN, 100, 100, 1, 1);   // dropped
    send_request(OP_ADD_MERGE, 200, 200, 1, 1);   // collapses
    for (int i = 0; i < 2; i++) send_request(OP_ADD_PLAIN, i * 5, 50, 5, 5);
    send_request(OP_ADD_MERGE, 300, 300, 2, 2);   // compaction makes room
    send_request(OP_DUMP, 0, 0, 0, 0);
    write_capacity(5'd1);                          // below stored count
    send_request(OP_ADD_PLAIN, 1, 1, 1, 1);
    send_request(OP_ADD_MERGE, -9, -9, 1, 1);
    write_capacity(5'd0);
    send_request(OP_ADD_MERGE, 1, 1, 1, 1);
    write_capacity(5'd31);                         // saturates
    send_request(OP_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++) send_request(OP_ADD_PLAIN, i * 3, 0, 1, 1);
    send_request(OP_DUMP, 0, 0, 0, 0);
  endtask

  task automatic test_back_pressure();
    stall_token++;
    for (int i = 0; i < 10; i++) send_random();
    send_request(OP_DUMP, 0, 0, 0, 0);
    wait_drained();
  endtask

  task automatic test_random_phase(int unsigned s_pct, int unsigned r_pct, int unsigned n);
    logic [4:0] caps [7] = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd2, 5'd9};
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 12 == 0) write_capacity(caps[$urandom_range(0, 6)]);
      send_random();
    end
    wait_drained();
  endtask

  initial begin
    cap_reg = 16;
    rect_count = 0;
    send_idle_pct = 8;
    recv_idle_pct = 62;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_edges_and_extremes();
    test_full_table();
    write_capacity(5'd16);
    test_back_pressure();
    test_random_phase(8, 62, 70);
    test_random_phase(62, 8, 70);
    test_random_phase(0, 0, 70);
    write_capacity(5'd16);
    repeat (50) @(posedge clk_i);
    $display("tb: %0d requests sent, %0d results checked over capacities 0 to 31",
             requests_sent, results_seen);
    $display("tb: adds, dumps, clears, compaction, collapse and long output stalls run");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
